// ----- rtl/core/complex_fixed_point_alu_unit_defines.svh -----
// Assertion macros for the complex ALU RTL.
// Depends on nothing; included by modules that assert.
`ifndef COMPLEX_FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl failed");
`define CFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lbl failed");
`else
`define CFA_ASSERT(lbl, clk, rst_n, prop)
`define CFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/core/cfa_pkg.sv -----
// Shared types and constants for the complex fixed-point ALU.
// Depends on nothing.
package cfa_pkg;
  typedef enum logic [2:0] {
    MODE_ADD = 3'd0, MODE_SUB = 3'd1, MODE_MUL = 3'd2, MODE_DIV = 3'd3,
    MODE_NEG = 3'd4, MODE_CONJ = 3'd5, MODE_MAG2 = 3'd6, MODE_MAG = 3'd7
  } mode_t;

  localparam int unsigned DIV_CAP_BITS = 40;
  localparam int unsigned QB = DIV_CAP_BITS + 2;
  localparam int unsigned NB = 64;

  typedef struct packed {
    logic [2:0] mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
  } op_t;

  typedef struct packed {
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic div_zero;
    logic overflow;
  } res_t;

  typedef struct packed {
    logic [2:0] mode;
    logic dz;
    logic sgn_re;
    logic sgn_im;
    logic [NB-1:0] num_re;
    logic [NB-1:0] num_im;
    logic [NB-1:0] den;
    logic [NB-1:0] rem_re;
    logic [NB-1:0] rem_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic [NB-1:0] sq_x;
    logic [NB-1:0] sq_res;
    logic [NB-1:0] sq_bit;
    logic [63:0] fin_re;
    logic [63:0] fin_im;
    logic fin_ovf;
  } cell_t;
endpackage

// ----- rtl/core/cfa_if.sv -----
// Valid/ready channel interface for the complex ALU.
// Depends on nothing; payload type is a parameter.
interface cfa_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/cfa_front.sv -----
// Front stages: sign-extend operands, form exact products, sums and divisor.
// Depends on cfa_pkg.
module cfa_front #(
  parameter int unsigned W = 32
) (
  input  logic clk,
  input  logic en,
  input  cfa_pkg::op_t op,
  output cfa_pkg::cell_t cout
);
  localparam int unsigned NBS = cfa_pkg::NB;
  localparam int unsigned NE = NBS + 1;
  localparam int unsigned PW = 2 * W;
  logic signed [W-1:0] ar, ai, br, bi;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r, p_aa_r, p_dd_r;
  logic signed [W-1:0] ar_r, ai_r, br_r, bi_r;
  logic [2:0] mode_r;
  logic signed [NE-1:0] e_re, e_im;
  logic [NBS-1:0] e_den, e_mag;
  logic [NBS-1:0] mr, mi;
  cfa_pkg::cell_t c;

  function automatic cfa_pkg::mode_t cfa_cast(input logic [2:0] m);
    return cfa_pkg::mode_t'(m);
  endfunction

  assign ar = op.a_re[W-1:0];
  assign ai = op.a_im[W-1:0];
  assign br = op.b_re[W-1:0];
  assign bi = op.b_im[W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r <= op.mode;
      ar_r <= ar; ai_r <= ai; br_r <= br; bi_r <= bi;
      p_rr_r <= PW'(ar) * PW'(br);
      p_ii_r <= PW'(ai) * PW'(bi);
      p_ri_r <= PW'(ar) * PW'(bi);
      p_ir_r <= PW'(ai) * PW'(br);
      p_bb_r <= PW'(br) * PW'(br);
      p_cc_r <= PW'(bi) * PW'(bi);
      p_aa_r <= PW'(ar) * PW'(ar);
      p_dd_r <= PW'(ai) * PW'(ai);
    end
  end

  always_comb begin
    c = '0;
    c.mode = mode_r;
    e_re = '0;
    e_im = '0;
    e_den = NBS'(p_bb_r) + NBS'(p_cc_r);
    e_mag = NBS'(p_aa_r) + NBS'(p_dd_r);
    unique case (cfa_cast(mode_r))
      cfa_pkg::MODE_ADD: begin e_re = NE'(ar_r) + NE'(br_r); e_im = NE'(ai_r) + NE'(bi_r); end
      cfa_pkg::MODE_SUB: begin e_re = NE'(ar_r) - NE'(br_r); e_im = NE'(ai_r) - NE'(bi_r); end
      cfa_pkg::MODE_MUL: begin
        e_re = NE'(p_rr_r) - NE'(p_ii_r);
        e_im = NE'(p_ri_r) + NE'(p_ir_r);
      end
      cfa_pkg::MODE_DIV: begin
        e_re = NE'(p_rr_r) + NE'(p_ii_r);
        e_im = NE'(p_ir_r) - NE'(p_ri_r);
      end
      cfa_pkg::MODE_NEG: begin e_re = -NE'(ar_r); e_im = -NE'(ai_r); end
      cfa_pkg::MODE_CONJ: begin e_re = NE'(ar_r); e_im = -NE'(ai_r); end
      cfa_pkg::MODE_MAG2: begin e_re = NE'(e_mag); e_im = '0; end
      default: begin e_re = NE'(e_mag); e_im = '0; end
    endcase
    mr = e_re[NE-1] ? NBS'(-e_re) : NBS'(e_re);
    mi = e_im[NE-1] ? NBS'(-e_im) : NBS'(e_im);
    c.sgn_re = e_re[NE-1];
    c.sgn_im = e_im[NE-1];
    c.num_re = mr;
    c.num_im = mi;
    c.den = e_den;
    c.dz = (mode_r == cfa_pkg::MODE_DIV) && (e_den == '0);
    c.sq_x = e_mag;
    c.sq_bit = NBS'(1) << (NBS - 2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= c;
    end
  end
endmodule

// ----- rtl/core/cfa_cell.sv -----
// One cell of the iterative chain: one restoring-divide fraction bit for both
// parts (when DIV_STEP is nonzero) and one square-root step.
// Depends on cfa_pkg.
module cfa_cell #(
  parameter int unsigned DIV_STEP = 1
) (
  input  logic clk,
  input  logic en,
  input  cfa_pkg::cell_t cin,
  output cfa_pkg::cell_t cout
);
  localparam int unsigned QB = cfa_pkg::QB;
  localparam int unsigned NB = cfa_pkg::NB;
  localparam logic [QB-1:0] CAP = QB'(1) << cfa_pkg::DIV_CAP_BITS;
  cfa_pkg::cell_t c;
  logic [NB:0] rr, ri;
  logic [QB-1:0] qr, qi;
  logic [NB-1:0] t;

  always_comb begin
    c = cin;
    qr = cin.q_re;
    qi = cin.q_im;
    if (DIV_STEP != 0) begin
      rr = {cin.rem_re, 1'b0};
      ri = {cin.rem_im, 1'b0};
      qr = {qr[QB-2:0], 1'b0};
      qi = {qi[QB-2:0], 1'b0};
      if (rr >= {1'b0, cin.den}) begin
        rr = rr - {1'b0, cin.den};
        qr[0] = 1'b1;
      end
      if (ri >= {1'b0, cin.den}) begin
        ri = ri - {1'b0, cin.den};
        qi[0] = 1'b1;
      end
      if (qr > CAP) qr = CAP;
      if (qi > CAP) qi = CAP;
      c.rem_re = rr[NB-1:0];
      c.rem_im = ri[NB-1:0];
    end else begin
      rr = '0;
      ri = '0;
    end
    c.q_re = qr;
    c.q_im = qi;
    t = cin.sq_res + cin.sq_bit;
    if (cin.sq_bit != '0) begin
      if (cin.sq_x >= t) begin
        c.sq_x = cin.sq_x - t;
        c.sq_res = (cin.sq_res >> 1) + cin.sq_bit;
      end else begin
        c.sq_res = cin.sq_res >> 1;
      end
    end
    c.sq_bit = cin.sq_bit >> 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= c;
    end
  end
endmodule

// ----- rtl/core/cfa_quot.sv -----
// Integer quotient cell: bit-serial long division of numerator by divisor,
// one quotient bit per cell over all numerator bits, capped at 2^40.
// Depends on cfa_pkg.
module cfa_quot #(
  parameter int unsigned BITPOS = 0
) (
  input  logic clk,
  input  logic en,
  input  cfa_pkg::cell_t cin,
  output cfa_pkg::cell_t cout
);
  localparam int unsigned QB = cfa_pkg::QB;
  localparam int unsigned NB = cfa_pkg::NB;
  localparam logic [QB-1:0] CAP = QB'(1) << cfa_pkg::DIV_CAP_BITS;
  cfa_pkg::cell_t c;
  logic [NB:0] rr, ri;
  logic [QB-1:0] qr, qi;

  always_comb begin
    c = cin;
    rr = {cin.rem_re, cin.num_re[BITPOS]};
    ri = {cin.rem_im, cin.num_im[BITPOS]};
    qr = cin.q_re;
    qi = cin.q_im;
    qr = (qr > (CAP >> 1)) ? CAP : {qr[QB-2:0], 1'b0};
    qi = (qi > (CAP >> 1)) ? CAP : {qi[QB-2:0], 1'b0};
    if (rr >= {1'b0, cin.den}) begin
      rr = rr - {1'b0, cin.den};
      if (qr != CAP) qr[0] = 1'b1;
    end
    if (ri >= {1'b0, cin.den}) begin
      ri = ri - {1'b0, cin.den};
      if (qi != CAP) qi[0] = 1'b1;
    end
    c.rem_re = rr[NB-1:0];
    c.rem_im = ri[NB-1:0];
    c.q_re = qr;
    c.q_im = qi;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= c;
    end
  end
endmodule

// ----- rtl/core/cfa_back.sv -----
// Back stage: select and saturate the final real and imaginary parts.
// Depends on cfa_pkg.
module cfa_back #(
  parameter int unsigned W = 32,
  parameter int unsigned FB = 16
) (
  input  cfa_pkg::cell_t cin,
  output cfa_pkg::res_t res
);
  localparam int unsigned NB = cfa_pkg::NB;
  localparam logic [NB-1:0] LIM = NB'(1) << (W - 1);
  localparam logic [NB-1:0] RND = (NB'(1) << FB) - NB'(1);

  logic ov_re, ov_im;
  logic [NB-1:0] m_re, m_im;
  logic n_re, n_im;
  logic [31:0] o_re, o_im;

  function automatic logic [31:0] satf(input logic neg, input logic [NB-1:0] mag,
                                       output logic ov);
    logic [NB-1:0] mm;
    mm = mag;
    ov = 1'b0;
    if (neg) begin
      if (mm > LIM) begin mm = LIM; ov = 1'b1; end
      mm = -mm;
    end else if (mm > LIM - NB'(1)) begin
      mm = LIM - NB'(1);
      ov = 1'b1;
    end
    return mm[31:0];
  endfunction

  always_comb begin
    n_re = cin.sgn_re;
    n_im = cin.sgn_im;
    m_re = cin.num_re;
    m_im = cin.num_im;
    unique case (cfa_pkg::mode_t'(cin.mode))
      cfa_pkg::MODE_MUL, cfa_pkg::MODE_MAG2: begin
        if (cin.sgn_re) m_re = (cin.num_re + RND) >> FB;
        else m_re = cin.num_re >> FB;
        if (cin.sgn_im) m_im = (cin.num_im + RND) >> FB;
        else m_im = cin.num_im >> FB;
        n_re = cin.sgn_re && (m_re != '0);
        n_im = cin.sgn_im && (m_im != '0);
      end
      cfa_pkg::MODE_DIV: begin
        m_re = NB'(cin.q_re);
        m_im = NB'(cin.q_im);
        n_re = cin.sgn_re && (cin.q_re != '0);
        n_im = cin.sgn_im && (cin.q_im != '0);
      end
      cfa_pkg::MODE_MAG: begin
        m_re = cin.sq_res;
        m_im = '0;
        n_re = 1'b0;
        n_im = 1'b0;
      end
      default: begin
      end
    endcase
    o_re = satf(n_re, m_re, ov_re);
    o_im = satf(n_im, m_im, ov_im);
    res.div_zero = cin.dz;
    if (cin.dz) begin
      res.res_re = '0;
      res.res_im = '0;
      res.overflow = 1'b0;
    end else begin
      res.res_re = o_re;
      res.res_im = o_im;
      res.overflow = ov_re | ov_im;
    end
  end
endmodule

// ----- rtl/core/complex_fixed_point_alu_unit.sv -----
// Complex fixed-point ALU: add, sub, mul, div, negate, conjugate, |a|^2, |a|.
// Depends on cfa_pkg, cfa_if, cfa_front, cfa_quot, cfa_cell, cfa_back and the defines header.
//
// Usage: items enter on the in channel (valid/ready, payload op_t) and one
// result per item leaves on the out channel (payload res_t), in order.
// Throughput: one item per cycle while out_ch does not stall. Pipeline: two
// product and sum stages, 64 quotient cells that bring down one numerator
// bit each, 32 cells that run the square-root steps, the first FRAC_BITS
// of which also form one quotient fraction bit, and an output register.
// The whole chain advances together when the output register is empty or
// being taken; a stalled receiver freezes every cell, and in_ready drops.
// Reset clears only the valid bits of the chain; payload needs no reset.
// Divide by zero gives zero parts with div_zero set; saturation sets overflow.
`include "complex_fixed_point_alu_unit_defines.svh"
module complex_fixed_point_alu_unit #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  cfa_if.sink in_ch,
  cfa_if.source out_ch
);
  localparam int unsigned W = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int unsigned NQ = cfa_pkg::NB;
  localparam int unsigned NS = 32;
  localparam int unsigned NC = (FRAC_BITS > NS) ? FRAC_BITS : NS;
  localparam int unsigned DEPTH = 2 + NQ + NC + 1;

  logic adv;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  cfa_pkg::cell_t front_c;
  cfa_pkg::cell_t q_init;
  cfa_pkg::cell_t qc [0:NQ];
  cfa_pkg::cell_t fc [0:NC];
  cfa_pkg::res_t res_c, out_r;

  assign adv = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld_r[DEPTH-1];
  assign out_ch.data = out_r;

  cfa_front #(.W(W)) u_front (
    .clk(clk), .en(adv), .op(in_ch.data), .cout(front_c)
  );

  always_comb begin
    q_init = front_c;
    q_init.rem_re = '0;
    q_init.rem_im = '0;
    q_init.q_re = '0;
    q_init.q_im = '0;
  end

  assign qc[0] = q_init;

  for (genvar g = 0; g < NQ; g++) begin : g_quot
    cfa_quot #(.BITPOS(NQ - 1 - g)) u_quot (
      .clk(clk), .en(adv), .cin(qc[g]), .cout(qc[g+1])
    );
  end

  assign fc[0] = qc[NQ];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    cfa_cell #(.DIV_STEP((g < FRAC_BITS) ? 1 : 0)) u_cell (
      .clk(clk), .en(adv), .cin(fc[g]), .cout(fc[g+1])
    );
  end

  cfa_back #(.W(W), .FB(FRAC_BITS)) u_back (.cin(fc[NC]), .res(res_c));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res_c;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  `CFA_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
  `CFA_ASSERT(a_ready_rule, clk, rst_n, in_ch.ready == (!out_ch.valid || out_ch.ready))
  `CFA_ASSERT(a_dz_clean, clk, rst_n, !(out_ch.valid && out_ch.data.div_zero && out_ch.data.overflow))
endmodule

// ----- verif/complex_fixed_point_alu_unit_checker.sv -----
// Scoreboard for the complex fixed-point ALU: watches both channels, predicts each result.
// Depends on cfa_pkg and cfa_if; instantiated beside the block by the testbench top.
module complex_fixed_point_alu_unit_checker
  import cfa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cfa_if.sink  in_mon,
  cfa_if.sink  out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   result_count,
  output int   ovf_count,
  output int   dz_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  res_t expected_results[$];

  function automatic logic [31:0] clamp_word(input wide_t v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic wide_t trunc_quotient(input wide_t num, input wide_t den);
    wide_t mag;
    wide_t q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< 16) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic wide_t floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return wide_t'(root);
  endfunction

  function automatic res_t alu_result(input op_t op);
    wide_t ar, ai, br, bi, t_re, t_im, den;
    logic ovf;
    res_t r;
    ar = $signed(op.a_re);
    ai = $signed(op.a_im);
    br = $signed(op.b_re);
    bi = $signed(op.b_im);
    ovf = 1'b0;
    r = '0;
    t_re = 0;
    t_im = 0;
    case (mode_t'(op.mode))
      MODE_ADD: begin
        t_re = ar + br;
        t_im = ai + bi;
      end
      MODE_SUB: begin
        t_re = ar - br;
        t_im = ai - bi;
      end
      MODE_MUL: begin
        t_re = (ar * br - ai * bi) >>> 16;
        t_im = (ar * bi + ai * br) >>> 16;
      end
      MODE_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_zero = 1'b1;
        end else begin
          t_re = trunc_quotient(ar * br + ai * bi, den);
          t_im = trunc_quotient(ai * br - ar * bi, den);
        end
      end
      MODE_NEG: begin
        t_re = -ar;
        t_im = -ai;
      end
      MODE_CONJ: begin
        t_re = ar;
        t_im = -ai;
      end
      MODE_MAG2: t_re = (ar * ar + ai * ai) >>> 16;
      default: begin
        den = ar * ar + ai * ai;
        t_re = floor_sqrt(den[63:0]);
      end
    endcase
    r.res_re = clamp_word(t_re, ovf);
    r.res_im = clamp_word(t_im, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
    ovf_count = 0;
    dz_count = 0;
  end

  // handshake signals settle after the driving edge; sample midway
  always @(negedge clk) begin
    res_t want;
    res_t got;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) expected_results.push_back(alu_result(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        result_count++;
        if (expected_results.size() == 0) begin
          $error("unexpected result re=%h im=%h", got.res_re, got.res_im);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.overflow) ovf_count++;
          if (got.div_zero) dz_count++;
          if (got.res_re !== want.res_re) begin
            $error("res_re expected %h actual %h", want.res_re, got.res_re);
            fail_count++;
          end
          if (got.res_im !== want.res_im) begin
            $error("res_im expected %h actual %h", want.res_im, got.res_im);
            fail_count++;
          end
          if (got.div_zero !== want.div_zero) begin
            $error("div_zero expected %b actual %b", want.div_zero, got.div_zero);
            fail_count++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow expected %b actual %b", want.overflow, got.overflow);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

// ----- verif/complex_fixed_point_alu_unit_test.sv -----
// Testbench top for the complex fixed-point ALU: clock, reset, stimulus and verdict.
// Depends on cfa_pkg, cfa_if, the block and complex_fixed_point_alu_unit_checker.
module complex_fixed_point_alu_unit_test;
  import cfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_ITEMS = 150;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int fail_count, pending_count, result_count, ovf_count, dz_count;
  int idle_cycles;
  int sent_count;

  cfa_if #(.payload_t(op_t)) in_ch ();
  cfa_if #(.payload_t(res_t)) out_ch ();

  complex_fixed_point_alu_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  complex_fixed_point_alu_unit_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_ch.sink),
    .out_mon(out_ch.sink),
    .fail_count(fail_count),
    .pending_count(pending_count),
    .result_count(result_count),
    .ovf_count(ovf_count),
    .dz_count(dz_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    out_ch.ready <= 1'b0;
    calm <= 1'b0;
  end

  // receiver: stall in random bursts until the calm tail
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_ch.ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 12);
        out_ch.ready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("complex_fixed_point_alu_unit_test: done, errors");
      $finish;
    end
  end

  task automatic send_op(input op_t op);
    logic took;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= op;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end
    sent_count++;
  endtask

  function automatic logic [31:0] pick_word(input int style);
    logic [31:0] w;
    case (style)
      0: w = $urandom();
      1: w = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: w = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: w = 32'h8000_0000;
          1: w = 32'h7fff_ffff;
          2: w = 32'h0;
          3: w = 32'hffff_ffff;
          4: w = 32'h0001_0000;
          default: w = 32'hffff_0000;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic op_t random_op();
    op_t op;
    int style;
    style = $urandom_range(0, 9);
    style = (style < 3) ? 0 : (style < 6) ? 1 : (style < 8) ? 2 : 3;
    op.mode = 3'($urandom_range(0, 7));
    op.a_re = pick_word(style);
    op.a_im = pick_word(style);
    op.b_re = pick_word($urandom_range(0, 3));
    op.b_im = pick_word($urandom_range(0, 3));
    if (op.mode == MODE_DIV && $urandom_range(0, 15) == 0) begin
      op.b_re = '0;
      op.b_im = '0;
    end
    return op;
  endfunction

  function automatic op_t make_op(input mode_t m, input logic [31:0] ar, input logic [31:0] ai,
                                  input logic [31:0] br, input logic [31:0] bi);
    op_t op;
    op.mode = m;
    op.a_re = ar;
    op.a_im = ai;
    op.b_re = br;
    op.b_im = bi;
    return op;
  endfunction

  initial begin
    idle_cycles = 0;
    sent_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(make_op(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff));
    send_op(make_op(MODE_ADD, 32'h0001_8000, 32'hfffe_0000, 32'h0002_4000, 32'h0000_1000));
    send_op(make_op(MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff));
    send_op(make_op(MODE_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000));
    send_op(make_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_op(make_op(MODE_MUL, 32'h0002_0000, 32'hffff_8000, 32'h0000_8000, 32'h0003_0000));
    send_op(make_op(MODE_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0));
    send_op(make_op(MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0));
    send_op(make_op(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0));
    send_op(make_op(MODE_DIV, 32'h0003_0000, 32'hfffc_0000, 32'h0001_0000, 32'h0002_0000));
    send_op(make_op(MODE_DIV, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h8000_0000));
    send_op(make_op(MODE_DIV, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0));
    send_op(make_op(MODE_NEG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    send_op(make_op(MODE_NEG, 32'h7fff_ffff, 32'h0001_2345, 32'hffff_ffff, 32'hffff_ffff));
    send_op(make_op(MODE_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    send_op(make_op(MODE_CONJ, 32'h0001_0000, 32'h7fff_ffff, 32'h0, 32'h0));
    send_op(make_op(MODE_MAG2, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    send_op(make_op(MODE_MAG2, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0));
    send_op(make_op(MODE_MAG2, 32'h0000_0001, 32'h0, 32'h0, 32'h0));
    send_op(make_op(MODE_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    send_op(make_op(MODE_MAG, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0));
    send_op(make_op(MODE_MAG, 32'h0000_0002, 32'h0000_0003, 32'h0, 32'h0));
    send_op(make_op(MODE_MAG, 32'h0, 32'h0, 32'h0, 32'h0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      send_op(random_op());
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results (%0d saturated, %0d zero divisors)",
             sent_count, result_count, ovf_count, dz_count);
    if (fail_count == 0) begin
      $display("complex_fixed_point_alu_unit_test: done, clean");
    end else begin
      $display("complex_fixed_point_alu_unit_test: done, errors");
    end
    $finish;
  end
endmodule
